// ----- hdl/pcap_pkg.sv -----
// Shared types and constants for the PWM period and duty capture unit.
`timescale 1ns / 1ps

package pcap_pkg;

    localparam int OVF_BITS    = 16;
    localparam int WEIGHT_BITS = 17;
    localparam int COUNT_BITS  = 16;
    localparam int SPAN_BITS   = 32;
    localparam int PROD_BITS   = OVF_BITS + WEIGHT_BITS;
    localparam int DUTY_BITS   = 7;
    localparam int DVD_BITS    = SPAN_BITS + DUTY_BITS;
    localparam int DIV_STEPS   = DVD_BITS;
    localparam int CNT_BITS    = $clog2(DIV_STEPS);

    localparam logic [OVF_BITS-1:0]    OVF_MAX       = {OVF_BITS{1'b1}};
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET  = 17'd65535;
    localparam logic [DUTY_BITS-1:0]   DUTY_MAX      = 7'd100;
    localparam logic [CNT_BITS-1:0]    DIV_LAST_STEP = CNT_BITS'(DIV_STEPS - 1);

    // Capture edge slots
    localparam logic [1:0] EDGE_FIRST  = 2'd0;
    localparam logic [1:0] EDGE_SECOND = 2'd1;
    localparam logic [1:0] EDGE_THIRD  = 2'd2;

    // Register index of overflow_weight
    localparam logic REG_OVERFLOW_WEIGHT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_SUM_P,
        ST_MUL_H,
        ST_SUM_H,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul_p;
        logic sum_p;
        logic mul_h;
        logic sum_h;
        logic scale;
        logic div_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic third_edge;
        logic zero_period;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// ----- hdl/pcap_ctrl.sv -----
// Sequencer for the capture unit: item accept, span arithmetic, divide, publish.
`timescale 1ns / 1ps

module pcap_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pcap_pkg::status_t status,
    output pcap_pkg::cmd_t    cmd
);

    pcap_pkg::state_t state_reg;
    pcap_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcap_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            pcap_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.third_edge) begin
                    state_next = pcap_pkg::ST_MUL_P;
                end
            end
            pcap_pkg::ST_MUL_P: begin
                cmd.mul_p  = 1'b1;
                state_next = pcap_pkg::ST_SUM_P;
            end
            pcap_pkg::ST_SUM_P: begin
                cmd.sum_p  = 1'b1;
                state_next = pcap_pkg::ST_MUL_H;
            end
            pcap_pkg::ST_MUL_H: begin
                cmd.mul_h  = 1'b1;
                state_next = pcap_pkg::ST_SUM_H;
            end
            pcap_pkg::ST_SUM_H: begin
                cmd.sum_h  = 1'b1;
                state_next = pcap_pkg::ST_SCALE;
            end
            pcap_pkg::ST_SCALE: begin
                cmd.scale  = 1'b1;
                // zero period: no divide, duty is forced to 0
                state_next = status.zero_period ? pcap_pkg::ST_DONE : pcap_pkg::ST_DIV;
            end
            pcap_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = pcap_pkg::ST_DONE;
                end
            end
            pcap_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = pcap_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pcap_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/pcap_datapath.sv -----
// Capture state, span multiply/add, serial duty divider and output register.
`timescale 1ns / 1ps

module pcap_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pcap_pkg::cmd_t                      cmd,
    output pcap_pkg::status_t                   status,
    input  logic [pcap_pkg::WEIGHT_BITS-1:0]    overflow_weight,
    input  logic                                s_overflow_seen,
    input  logic                                s_edge_seen,
    input  logic [pcap_pkg::COUNT_BITS-1:0]     s_capture_count,
    input  logic                                s_pin_level,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcap_pkg::SPAN_BITS-1:0]      m_period_counts,
    output logic [pcap_pkg::SPAN_BITS-1:0]      m_high_counts,
    output logic [pcap_pkg::DUTY_BITS-1:0]      m_duty_percent,
    output logic                                m_zero_period
);

    localparam int OB = pcap_pkg::OVF_BITS;
    localparam int CB = pcap_pkg::COUNT_BITS;
    localparam int SB = pcap_pkg::SPAN_BITS;
    localparam int PB = pcap_pkg::PROD_BITS;
    localparam int DB = pcap_pkg::DVD_BITS;
    localparam int QB = pcap_pkg::DUTY_BITS;
    localparam int NB = pcap_pkg::CNT_BITS;

    // capture state
    logic [OB-1:0] ovf_total_reg,  ovf_total_next;
    logic [1:0]    edge_idx_reg,   edge_idx_next;
    logic [CB-1:0] first_reg,      first_next;
    logic [CB-1:0] second_reg,     second_next;
    logic [OB-1:0] ovf_first_reg,  ovf_first_next;
    logic [OB-1:0] ovf_second_reg, ovf_second_next;
    logic          rising_reg,     rising_next;

    // working registers for one measurement
    logic [CB-1:0] count_reg,  count_next;
    logic [OB-1:0] diff_p_reg, diff_p_next;
    logic [OB-1:0] diff_h_reg, diff_h_next;
    logic [PB-1:0] prod_reg,   prod_next;
    logic [SB-1:0] period_reg, period_next;
    logic [SB-1:0] high_reg,   high_next;
    logic [DB-1:0] dvd_reg,    dvd_next;
    logic [SB-1:0] rem_reg,    rem_next;
    logic [NB-1:0] cnt_reg,    cnt_next;

    // output register
    logic          out_valid_reg,  out_valid_next;
    logic [SB-1:0] out_period_reg, out_period_next;
    logic [SB-1:0] out_high_reg,   out_high_next;
    logic [QB-1:0] out_duty_reg,   out_duty_next;
    logic          out_zero_reg,   out_zero_next;

    logic [OB-1:0] ovf_now;
    logic [SB:0]   rem_sh;
    logic          rem_ge;
    logic [QB-1:0] duty_clamped;

    assign ovf_now = ovf_total_reg
                   + OB'(s_overflow_seen && (ovf_total_reg != pcap_pkg::OVF_MAX));

    assign rem_sh = {rem_reg, dvd_reg[DB-1]};
    assign rem_ge = rem_sh >= {1'b0, period_reg};

    assign duty_clamped = (dvd_reg > DB'(pcap_pkg::DUTY_MAX)) ? pcap_pkg::DUTY_MAX
                                                              : dvd_reg[QB-1:0];

    assign status.third_edge  = s_edge_seen && (edge_idx_reg == pcap_pkg::EDGE_THIRD);
    assign status.zero_period = (period_reg == '0);
    assign status.div_last    = (cnt_reg == pcap_pkg::DIV_LAST_STEP);
    assign status.out_free    = !out_valid_reg || m_tready;

    always_comb begin
        ovf_total_next  = ovf_total_reg;
        edge_idx_next   = edge_idx_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        ovf_first_next  = ovf_first_reg;
        ovf_second_next = ovf_second_reg;
        rising_next     = rising_reg;
        count_next      = count_reg;
        diff_p_next     = diff_p_reg;
        diff_h_next     = diff_h_reg;
        prod_next       = prod_reg;
        period_next     = period_reg;
        high_next       = high_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        out_period_next = out_period_reg;
        out_high_next   = out_high_reg;
        out_duty_next   = out_duty_reg;
        out_zero_next   = out_zero_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        if (cmd.accept) begin
            ovf_total_next = ovf_now;
            if (s_edge_seen) begin
                case (edge_idx_reg)
                    pcap_pkg::EDGE_FIRST: begin
                        first_next     = s_capture_count;
                        ovf_first_next = ovf_now;
                        rising_next    = s_pin_level;
                        edge_idx_next  = pcap_pkg::EDGE_SECOND;
                    end
                    pcap_pkg::EDGE_SECOND: begin
                        second_next     = s_capture_count;
                        ovf_second_next = ovf_now;
                        edge_idx_next   = pcap_pkg::EDGE_THIRD;
                    end
                    pcap_pkg::EDGE_THIRD: begin
                        count_next  = s_capture_count;
                        diff_p_next = ovf_now - ovf_first_reg;
                        diff_h_next = rising_reg ? (ovf_second_reg - ovf_first_reg)
                                                 : (ovf_now - ovf_second_reg);
                        // restart: captures and edge polarity are kept
                        edge_idx_next   = pcap_pkg::EDGE_FIRST;
                        ovf_total_next  = '0;
                        ovf_first_next  = '0;
                        ovf_second_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (cmd.mul_p) begin
            prod_next = PB'(diff_p_reg) * PB'(overflow_weight);
        end
        if (cmd.sum_p) begin
            period_next = SB'(count_reg) + prod_reg[SB-1:0] - SB'(first_reg);
        end
        if (cmd.mul_h) begin
            prod_next = PB'(diff_h_reg) * PB'(overflow_weight);
        end
        if (cmd.sum_h) begin
            if (rising_reg) begin
                high_next = SB'(second_reg) + prod_reg[SB-1:0] - SB'(first_reg);
            end else begin
                high_next = SB'(count_reg) + prod_reg[SB-1:0] - SB'(second_reg);
            end
        end
        if (cmd.scale) begin
            dvd_next = DB'(high_reg) * DB'(pcap_pkg::DUTY_MAX);
            rem_next = '0;
            cnt_next = '0;
        end
        if (cmd.div_step) begin
            // restoring divide, one quotient bit per cycle into the dividend
            rem_next = rem_ge ? SB'(rem_sh - {1'b0, period_reg}) : rem_sh[SB-1:0];
            dvd_next = {dvd_reg[DB-2:0], rem_ge};
            cnt_next = cnt_reg + NB'(1);
        end
        if (cmd.publish) begin
            out_valid_next  = 1'b1;
            out_period_next = period_reg;
            out_high_next   = high_reg;
            out_zero_next   = status.zero_period;
            out_duty_next   = status.zero_period ? '0 : duty_clamped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_total_reg  <= '0;
            edge_idx_reg   <= pcap_pkg::EDGE_FIRST;
            first_reg      <= '0;
            second_reg     <= '0;
            ovf_first_reg  <= '0;
            ovf_second_reg <= '0;
            rising_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            ovf_total_reg  <= ovf_total_next;
            edge_idx_reg   <= edge_idx_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            ovf_first_reg  <= ovf_first_next;
            ovf_second_reg <= ovf_second_next;
            rising_reg     <= rising_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg      <= count_next;
        diff_p_reg     <= diff_p_next;
        diff_h_reg     <= diff_h_next;
        prod_reg       <= prod_next;
        period_reg     <= period_next;
        high_reg       <= high_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        out_period_reg <= out_period_next;
        out_high_reg   <= out_high_next;
        out_duty_reg   <= out_duty_next;
        out_zero_reg   <= out_zero_next;
    end

    assign m_tvalid        = out_valid_reg;
    assign m_period_counts = out_period_reg;
    assign m_high_counts   = out_high_reg;
    assign m_duty_percent  = out_duty_reg;
    assign m_zero_period   = out_zero_reg;

endmodule

// ----- hdl/pwm_period_duty_capture_unit.sv -----
// Top level of the PWM period and duty capture unit with its APB register.
`timescale 1ns / 1ps

// Measures a PWM waveform from timer capture events.
// Input channel (s_): one item per timer event. tuser carries the overflow
// and edge flags, tdata the captured count and the pin level. Events without
// an edge only bump the saturating overflow counter. The first and second
// edges are recorded; the third produces one result item and restarts.
// Result channel (m_): period and high time in timer counts, each extended
// by overflow_weight counts per overflow, plus duty in whole percent
// (clamped to 100); tuser flags a zero period, which forces duty to 0.
// Sequence: non-final events are accepted back to back. The closing edge is
// followed by two multiply/add pairs, a scale by 100 and a 39-step
// restoring divider at one quotient bit per cycle; with a zero period
// the divider is skipped. The result is then loaded into the output register.
// The input accepts nothing while a measurement is being computed.
// The output is a register: a stalled receiver does not block new items
// until the next result is ready and the register is still full.
// Reset (aresetn low, synchronous) clears the capture state, drops any
// pending result and sets overflow_weight back to 65535.
// APB: one register, overflow_weight, at byte address 0 (17 bits used).
module pwm_period_duty_capture_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // capture_count[15:0], pin_level[16], zero fill
    input  logic [1:0]  s_tuser,   // overflow_seen[0], edge_seen[1]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // period_counts[31:0], high_counts[63:32],
                                   // duty_percent[70:64], zero fill
    output logic [0:0]  m_tuser,   // zero_period[0]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WB = pcap_pkg::WEIGHT_BITS;
    localparam int SB = pcap_pkg::SPAN_BITS;
    localparam int QB = pcap_pkg::DUTY_BITS;

    logic [WB-1:0] weight_reg, weight_next;
    logic          reg_hit;

    pcap_pkg::cmd_t    cmd;
    pcap_pkg::status_t status;

    logic [SB-1:0] period_counts;
    logic [SB-1:0] high_counts;
    logic [QB-1:0] duty_percent;
    logic          zero_period;

    // register decode: word index is paddr[2]
    assign reg_hit = (paddr[2] == pcap_pkg::REG_OVERFLOW_WEIGHT);
    assign pready  = 1'b1;

    always_comb begin
        weight_next = weight_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            weight_next = pwdata[WB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= pcap_pkg::WEIGHT_RESET;
        end else begin
            weight_reg <= weight_next;
        end
    end

    assign prdata = reg_hit ? {{(32-WB){1'b0}}, weight_reg} : '0;

    pcap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcap_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .overflow_weight (weight_reg),
        .s_overflow_seen (s_tuser[0]),
        .s_edge_seen     (s_tuser[1]),
        .s_capture_count (s_tdata[15:0]),
        .s_pin_level     (s_tdata[16]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_period_counts (period_counts),
        .m_high_counts   (high_counts),
        .m_duty_percent  (duty_percent),
        .m_zero_period   (zero_period)
    );

    assign m_tdata = {1'b0, duty_percent, high_counts, period_counts};
    assign m_tuser = zero_period;

endmodule

// ----- tb/sv/pwm_period_duty_capture_unit_tb.sv -----
// Self-checking testbench for the PWM period and duty capture unit.
`timescale 1ns / 1ps

module pwm_period_duty_capture_unit_tb;

    // 8 ns clock, reset length in cycles, generous cap on the whole run
    localparam int      RESET_CYCLES = 5;
    localparam int      SETTLE_CYCLES = 60;     // settle time once all results have drained
    localparam int      PHASE_ITEMS = 105;
    localparam int      HOLD_CYCLES = 600;
    localparam int      SPAN_OVERFLOWS = 40;    // overflows inside one wide span
    localparam longint  TIMEOUT_NS = 64'd8_000_000;

    // Register map: overflow_weight at index 0, one unmapped slot after it
    localparam logic [2:0] WEIGHT_ADDR   = 3'(pcap_pkg::REG_OVERFLOW_WEIGHT) << 2;
    localparam logic [2:0] UNMAPPED_ADDR = WEIGHT_ADDR + 3'd4;

    // One measurement as it leaves the block
    typedef struct packed {
        logic [pcap_pkg::SPAN_BITS-1:0] period;
        logic [pcap_pkg::SPAN_BITS-1:0] high;
        logic [pcap_pkg::DUTY_BITS-1:0] duty;
        logic                           zero;
    } measure_t;

    // Tracks the capture state and queues the measurement each closing edge yields
    class pwm_capture_checker;
        logic [pcap_pkg::WEIGHT_BITS-1:0] weight;
        logic [pcap_pkg::OVF_BITS-1:0]    ovf_total;
        logic [pcap_pkg::OVF_BITS-1:0]    ovf_first;
        logic [pcap_pkg::OVF_BITS-1:0]    ovf_second;
        logic [1:0]                       edge_slot;
        logic [pcap_pkg::COUNT_BITS-1:0]  first_cap;
        logic [pcap_pkg::COUNT_BITS-1:0]  second_cap;
        logic                             first_rising;
        measure_t                         pending_measures[$];
        int                               errors;
        int                               matched;

        function new();
            weight       = pcap_pkg::WEIGHT_RESET;
            ovf_total    = '0;
            ovf_first    = '0;
            ovf_second   = '0;
            edge_slot    = pcap_pkg::EDGE_FIRST;
            first_cap    = '0;
            second_cap   = '0;
            first_rising = 1'b0;
            errors       = 0;
            matched      = 0;
        endfunction

        function void set_weight(logic [31:0] value);
            weight = value[pcap_pkg::WEIGHT_BITS-1:0];
        endfunction

        // Count difference plus weighted overflows, wrapped to 32 bits
        function logic [pcap_pkg::SPAN_BITS-1:0] span(
                logic [pcap_pkg::COUNT_BITS-1:0] start_cnt,
                logic [pcap_pkg::COUNT_BITS-1:0] stop_cnt,
                logic [pcap_pkg::OVF_BITS-1:0]   from_ovf,
                logic [pcap_pkg::OVF_BITS-1:0]   to_ovf);
            logic [63:0] ovf_diff;
            logic [63:0] total;
            ovf_diff = (64'(to_ovf) - 64'(from_ovf)) & 64'hFFFF_FFFF;
            total    = 64'(stop_cnt) + ovf_diff * 64'(weight) - 64'(start_cnt);
            return total[pcap_pkg::SPAN_BITS-1:0];
        endfunction

        function void take_event(logic ovf_flag, logic edge_flag,
                                 logic [pcap_pkg::COUNT_BITS-1:0] count, logic level);
            measure_t    m;
            logic [63:0] quot;
            if (ovf_flag && ovf_total != pcap_pkg::OVF_MAX)
                ovf_total++;
            if (!edge_flag)
                return;
            case (edge_slot)
                pcap_pkg::EDGE_FIRST: begin
                    first_cap    = count;
                    ovf_first    = ovf_total;
                    first_rising = level;
                    edge_slot    = pcap_pkg::EDGE_SECOND;
                end
                pcap_pkg::EDGE_SECOND: begin
                    second_cap = count;
                    ovf_second = ovf_total;
                    edge_slot  = pcap_pkg::EDGE_THIRD;
                end
                pcap_pkg::EDGE_THIRD: begin
                    m.period = span(first_cap, count, ovf_first, ovf_total);
                    if (first_rising)
                        m.high = span(first_cap, second_cap, ovf_first, ovf_second);
                    else
                        m.high = span(second_cap, count, ovf_second, ovf_total);
                    if (m.period == '0) begin
                        m.zero = 1'b1;
                        m.duty = '0;
                    end else begin
                        m.zero = 1'b0;
                        quot   = (64'(m.high) * 64'd100) / 64'(m.period);
                        if (quot > 64'(pcap_pkg::DUTY_MAX))
                            quot = 64'(pcap_pkg::DUTY_MAX);
                        m.duty = quot[pcap_pkg::DUTY_BITS-1:0];
                    end
                    pending_measures.push_back(m);
                    edge_slot  = pcap_pkg::EDGE_FIRST;
                    ovf_total  = '0;
                    ovf_first  = '0;
                    ovf_second = '0;
                end
                default: ;  // slot value 3 is unreachable; an edge there is dropped
            endcase
        endfunction

        function void check_measure(logic [71:0] data, logic [0:0] user);
            measure_t exp;
            measure_t got;
            got.period = data[31:0];
            got.high   = data[63:32];
            got.duty   = data[70:64];
            got.zero   = user[0];
            if (pending_measures.size() == 0) begin
                $display("%0t: unexpected measurement period %h high %h duty %0d zero %b",
                         $time, got.period, got.high, got.duty, got.zero);
                errors++;
                return;
            end
            exp = pending_measures.pop_front();
            if (got.period !== exp.period) begin
                $display("%0t: period mismatch expected %h actual %h",
                         $time, exp.period, got.period);
                errors++;
            end
            if (got.high !== exp.high) begin
                $display("%0t: high time mismatch expected %h actual %h",
                         $time, exp.high, got.high);
                errors++;
            end
            if (got.duty !== exp.duty) begin
                $display("%0t: duty mismatch expected %0d actual %0d",
                         $time, exp.duty, got.duty);
                errors++;
            end
            if (got.zero !== exp.zero) begin
                $display("%0t: zero-period flag mismatch expected %b actual %b",
                         $time, exp.zero, got.zero);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // capture_count[15:0], pin_level[16], zero fill
    logic [1:0]  s_tuser;    // overflow_seen[0], edge_seen[1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;    // period_counts[31:0], high_counts[63:32], duty_percent[70:64]
    logic [0:0]  m_tuser;    // zero_period[0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pwm_capture_checker capture_model;

    int send_idle_pct = 0;   // chance per cycle that the sender sits out
    int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int recv_hold = 0;       // long hold-off, counted down by the receiver
    int items_sent = 0;
    int reg_writes = 0;

    pwm_period_duty_capture_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Result side: check each accepted item, then pick next cycle's tready.
    // A pending hold-off overrides the random stalls.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            capture_model.check_measure(m_tdata, m_tuser);
        if (recv_hold > 0) begin
            m_tready  <= 1'b0;
            recv_hold  = recv_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hard stop in case the handshakes never complete
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: run timed out", $time);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one timer event; returns at the edge where it was taken, tvalid still high
    task automatic send_event(logic ovf_flag, logic edge_flag,
                              logic [pcap_pkg::COUNT_BITS-1:0] count, logic level);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {edge_flag, ovf_flag};
        s_tdata  <= {7'b0, level, count};
        do @(posedge aclk); while (!s_tready);
        capture_model.take_event(ovf_flag, edge_flag, count, level);
        items_sent++;
    endtask

    // Drop tvalid, let all results drain, then cover the block's latency
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (capture_model.pending_measures.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write, setup then access phase; only called while the block is idle
    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WEIGHT_ADDR)
            capture_model.set_weight(value);
        reg_writes++;
    endtask

    // Edges in slots EDGE_FIRST to EDGE_THIRD, each after zero to 40 overflow-only events.
    // Half the time the counts climb in small steps, otherwise anything goes.
    task automatic send_measure();
        logic [pcap_pkg::COUNT_BITS-1:0] cnt;
        int                              gaps;
        bit                              close_counts;
        close_counts = $urandom_range(1);
        cnt          = 16'($urandom);
        for (int k = 0; k < 3; k++) begin
            gaps = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3);
            repeat (gaps)
                send_event(1'b1, 1'b0, 16'($urandom), 1'($urandom));
            send_event(1'($urandom), 1'b1, cnt, 1'($urandom));
            if (close_counts)
                cnt = cnt + 16'($urandom_range(3000));
            else
                cnt = 16'($urandom);
        end
    endtask

    task automatic run_random(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80)
                send_measure();
            else
                send_event(1'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        capture_model = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset weight of 65535
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // rising start edge, overflows before the closing edge
        send_event(1'b0, 1'b1, 16'd100, 1'b1);
        send_event(1'b0, 1'b1, 16'd400, 1'b0);
        send_event(1'b1, 1'b0, 16'd0, 1'b0);
        send_event(1'b1, 1'b1, 16'd1100, 1'b1);
        // third count equals the first: zero period
        send_event(1'b0, 1'b1, 16'd5000, 1'b0);
        send_event(1'b0, 1'b1, 16'd6000, 1'b1);
        send_event(1'b0, 1'b1, 16'd5000, 1'b0);
        // high time longer than the period: duty clamps
        send_event(1'b0, 1'b1, 16'd100, 1'b1);
        send_event(1'b0, 1'b1, 16'd60000, 1'b0);
        send_event(1'b0, 1'b1, 16'd200, 1'b1);
        // counts run backwards: spans wrap below zero
        send_event(1'b0, 1'b1, 16'd60000, 1'b0);
        send_event(1'b0, 1'b1, 16'd100, 1'b1);
        send_event(1'b0, 1'b1, 16'd50, 1'b0);
        // count extremes with overflow on every edge
        send_event(1'b1, 1'b1, 16'hFFFF, 1'b1);
        send_event(1'b1, 1'b1, 16'h0000, 1'b0);
        send_event(1'b1, 1'b1, 16'hFFFF, 1'b1);
        // falling first edge, overflow between second and third
        send_event(1'b0, 1'b1, 16'd300, 1'b0);
        send_event(1'b0, 1'b1, 16'd900, 1'b1);
        send_event(1'b1, 1'b0, 16'hFFFF, 1'b1);
        send_event(1'b0, 1'b1, 16'd200, 1'b0);
        wait_idle();

        // Smallest nonzero weight
        apb_write(WEIGHT_ADDR, 32'd1);
        send_event(1'b0, 1'b1, 16'd10, 1'b1);
        send_event(1'b1, 1'b1, 16'd20, 1'b0);
        send_event(1'b1, 1'b1, 16'd5, 1'b1);
        wait_idle();
        // A write outside the map must leave the weight alone
        apb_write(UNMAPPED_ADDR, $urandom);

        // Weight of 65536, with a run of overflows inside the first span
        apb_write(WEIGHT_ADDR, 32'd65536);
        send_event(1'b0, 1'b1, 16'd0, 1'b1);
        repeat (SPAN_OVERFLOWS)
            send_event(1'b1, 1'b0, 16'($urandom), 1'($urandom));
        send_event(1'b1, 1'b1, 16'd0, 1'b0);
        send_event(1'b1, 1'b1, 16'd0, 1'b1);
        run_random(PHASE_ITEMS);

        // Receiver goes quiet while the sender keeps going: output and input back up
        recv_hold = HOLD_CYCLES;
        repeat (4) begin
            send_event(1'b0, 1'b1, 16'($urandom), 1'($urandom));
            send_event(1'b0, 1'b1, 16'($urandom), 1'($urandom));
            send_event(1'b0, 1'b1, 16'($urandom), 1'($urandom));
        end
        wait_idle();

        // Sparse sender
        apb_write(WEIGHT_ADDR, 32'($urandom_range(65536, 1)));
        send_idle_pct  = 69;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        wait_idle();

        // Slow receiver
        apb_write(WEIGHT_ADDR, 32'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        run_random(PHASE_ITEMS);
        wait_idle();

        // Both sides idle now and then
        apb_write(WEIGHT_ADDR, 32'($urandom_range(65536, 1)));
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        run_random(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_idle();

        if (capture_model.pending_measures.size() != 0) begin
            $display("%0t: %0d measurements never arrived",
                     $time, capture_model.pending_measures.size());
            capture_model.errors++;
        end

        $display("Sent %0d timer events over four idle mixes, checked %0d measurements,",
                 items_sent, capture_model.matched);
        $display("%0d register writes; zero period, duty clamp, wrapped spans, long stall.",
                 reg_writes);
        if (capture_model.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
